// ===== hw/rtl/pop3rp_pkg.sv =====
// shared types, codes and helpers for the pop3 response parser
`timescale 1ns / 1ps

package pop3rp_pkg;

    localparam int DEF_MAX_STATUS_LEN = 512;
    localparam int DEF_MAX_LINE_LEN   = 512;

    // result kinds
    localparam logic [2:0] RK_STATUS = 3'd0;
    localparam logic [2:0] RK_NUMBER = 3'd1;
    localparam logic [2:0] RK_TEXT   = 3'd2;
    localparam logic [2:0] RK_END    = 3'd3;
    localparam logic [2:0] RK_ERROR  = 3'd4;

    // response kinds
    localparam logic [2:0] KIND_SINGLE = 3'd0;
    localparam logic [2:0] KIND_STAT   = 3'd1;
    localparam logic [2:0] KIND_LIST   = 3'd2;
    localparam logic [2:0] KIND_UIDL   = 3'd3;
    localparam logic [2:0] KIND_BODY   = 3'd4;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [4:0] {
        PH_IDLE   = 5'b00001,
        PH_STATUS = 5'b00010,
        PH_LIST   = 5'b00100,
        PH_UIDL   = 5'b01000,
        PH_BODY   = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic        ok;
        logic [31:0] number;
        logic [7:0]  text;
        logic        item_end;
        logic        done;
    } result_t;

    // up to two results produced by one received byte
    typedef struct packed {
        logic [1:0] cnt;
        result_t    r0;
        result_t    r1;
    } push_t;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    // acc * 10 + digit, saturating at all ones
    function automatic logic [31:0] acc_step(input logic [31:0] acc, input logic [7:0] b);
        logic [35:0] wide;
        logic [7:0]  d;
        d    = b - CH_ZERO;
        wide = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {32'd0, d[3:0]};
        return (wide[35:32] != 4'd0) ? 32'hFFFF_FFFF : wide[31:0];
    endfunction

endpackage

// ===== hw/rtl/pop3_response_parser_top.sv =====
// output: a byte's results are registered in the result queue behind earlier ones
// throughput: one byte per cycle while the result side keeps up; a byte can yield
//   up to two results, taken one per cycle while out_ready is high, and in_ready
//   drops when the four-entry result queue has fewer than two free slots
// reset: asynchronous, active low; clears the parse state and empties the queue
`timescale 1ns / 1ps

module pop3_response_parser_top #(
    parameter int MAX_STATUS_LEN = pop3rp_pkg::DEF_MAX_STATUS_LEN,
    parameter int MAX_LINE_LEN   = pop3rp_pkg::DEF_MAX_LINE_LEN
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    input  logic [2:0]  response_kind,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  result_kind,
    output logic        status_ok,
    output logic [31:0] number_value,
    output logic [7:0]  text_byte,
    output logic        item_end,
    output logic        response_done
);

    pop3rp_pkg::push_t   push;
    pop3rp_pkg::result_t head;
    logic                room;
    logic                accept;

    assign in_ready = room;
    assign accept   = in_valid && room;

    pop3rp_core #(
        .MAX_STATUS_LEN (MAX_STATUS_LEN),
        .MAX_LINE_LEN   (MAX_LINE_LEN)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .rx_byte       (rx_byte),
        .response_kind (response_kind),
        .push          (push)
    );

    pop3rp_resq u_resq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign result_kind   = head.kind;
    assign status_ok     = head.ok;
    assign number_value  = head.number;
    assign text_byte     = head.text;
    assign item_end      = head.item_end;
    assign response_done = head.done;

endmodule

// ===== hw/rtl/pop3rp_core.sv =====
// per-byte parse state and result generation
`timescale 1ns / 1ps

module pop3rp_core #(
    parameter int MAX_STATUS_LEN = pop3rp_pkg::DEF_MAX_STATUS_LEN,
    parameter int MAX_LINE_LEN   = pop3rp_pkg::DEF_MAX_LINE_LEN
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [7:0]         rx_byte,
    input  logic [2:0]         response_kind,
    output pop3rp_pkg::push_t  push
);

    localparam int MAX_LEN = (MAX_STATUS_LEN > MAX_LINE_LEN) ? MAX_STATUS_LEN : MAX_LINE_LEN;
    localparam int LEN_W   = $clog2(MAX_LEN + 1);
    localparam logic [LEN_W-1:0] STATUS_LIMIT = LEN_W'(MAX_STATUS_LEN);
    localparam logic [LEN_W-1:0] LINE_LIMIT   = LEN_W'(MAX_LINE_LEN);

    pop3rp_pkg::phase_t phase_reg, phase_next;
    logic [2:0]       kind_reg, kind_next;
    logic             ok_reg, ok_next;
    logic             cr_reg, cr_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [1:0]       sp_reg, sp_next;
    logic [31:0]      acc_reg, acc_next;
    logic             hc_reg, hc_next;
    logic [7:0]       hib_reg, hib_next;
    logic             hiv_reg, hiv_next;

    logic             fail;
    logic             clr;
    logic [LEN_W-1:0] limit;
    pop3rp_pkg::result_t r0, r1;
    logic [1:0]       cnt;

    always_comb
    begin
        phase_next = phase_reg;
        kind_next  = kind_reg;
        ok_next    = ok_reg;
        cr_next    = cr_reg;
        len_next   = len_reg;
        sp_next    = sp_reg;
        acc_next   = acc_reg;
        hc_next    = hc_reg;
        hib_next   = hib_reg;
        hiv_next   = hiv_reg;
        fail       = 1'b0;
        clr        = 1'b0;
        r0         = '0;
        r1         = '0;
        cnt        = 2'd0;

        // first byte of a response samples the kind and the status sign
        if (phase_next == pop3rp_pkg::PH_IDLE)
        begin
            kind_next  = (response_kind <= pop3rp_pkg::KIND_BODY) ? response_kind
                                                                  : pop3rp_pkg::KIND_SINGLE;
            ok_next    = (rx_byte == pop3rp_pkg::CH_PLUS);
            cr_next    = 1'b0;
            len_next   = '0;
            sp_next    = 2'd0;
            acc_next   = '0;
            hc_next    = 1'b0;
            hib_next   = '0;
            hiv_next   = 1'b0;
            phase_next = pop3rp_pkg::PH_STATUS;
        end

        limit = (phase_next == pop3rp_pkg::PH_STATUS) ? STATUS_LIMIT : LINE_LIMIT;

        if (len_next >= limit)
        begin
            fail = 1'b1;
        end
        else
        begin
            len_next = len_next + LEN_W'(1);
            if (cr_next)
            begin
                if (rx_byte != pop3rp_pkg::CH_LF)
                begin
                    fail = 1'b1;
                end
                else if (phase_next == pop3rp_pkg::PH_STATUS)
                begin
                    if (!ok_next || kind_next == pop3rp_pkg::KIND_SINGLE)
                    begin
                        r0.kind    = pop3rp_pkg::RK_STATUS;
                        r0.ok      = ok_next;
                        r0.done    = 1'b1;
                        cnt        = 2'd1;
                        clr        = 1'b1;
                        phase_next = pop3rp_pkg::PH_IDLE;
                    end
                    else if (kind_next == pop3rp_pkg::KIND_STAT)
                    begin
                        if (sp_next == 2'd0)
                        begin
                            fail = 1'b1;
                        end
                        else
                        begin
                            r0.kind    = pop3rp_pkg::RK_STATUS;
                            r0.ok      = 1'b1;
                            r1.kind    = pop3rp_pkg::RK_NUMBER;
                            r1.number  = acc_next;
                            r1.done    = 1'b1;
                            cnt        = 2'd2;
                            clr        = 1'b1;
                            phase_next = pop3rp_pkg::PH_IDLE;
                        end
                    end
                    else
                    begin
                        r0.kind = pop3rp_pkg::RK_STATUS;
                        r0.ok   = 1'b1;
                        cnt     = 2'd1;
                        clr     = 1'b1;
                        if (kind_next == pop3rp_pkg::KIND_LIST)
                            phase_next = pop3rp_pkg::PH_LIST;
                        else if (kind_next == pop3rp_pkg::KIND_UIDL)
                            phase_next = pop3rp_pkg::PH_UIDL;
                        else
                            phase_next = pop3rp_pkg::PH_BODY;
                    end
                end
                else if (hc_next)
                begin
                    // terminating dot line
                    r0.kind    = pop3rp_pkg::RK_END;
                    r0.done    = 1'b1;
                    cnt        = 2'd1;
                    clr        = 1'b1;
                    phase_next = pop3rp_pkg::PH_IDLE;
                end
                else if (phase_next == pop3rp_pkg::PH_LIST)
                begin
                    if (sp_next == 2'd0)
                    begin
                        fail = 1'b1;
                    end
                    else
                    begin
                        r0.kind   = pop3rp_pkg::RK_NUMBER;
                        r0.number = acc_next;
                        cnt       = 2'd1;
                        clr       = 1'b1;
                    end
                end
                else if (phase_next == pop3rp_pkg::PH_UIDL)
                begin
                    if (sp_next == 2'd0)
                    begin
                        fail = 1'b1;
                    end
                    else
                    begin
                        if (hiv_next)
                        begin
                            r0.kind     = pop3rp_pkg::RK_TEXT;
                            r0.text     = hib_next;
                            r0.item_end = 1'b1;
                            cnt         = 2'd1;
                        end
                        clr = 1'b1;
                    end
                end
                else
                begin
                    r0.kind = pop3rp_pkg::RK_TEXT;
                    r0.text = pop3rp_pkg::CH_CR;
                    r1.kind = pop3rp_pkg::RK_TEXT;
                    r1.text = pop3rp_pkg::CH_LF;
                    cnt     = 2'd2;
                    clr     = 1'b1;
                end
            end
            else if (rx_byte == pop3rp_pkg::CH_CR)
            begin
                cr_next = 1'b1;
            end
            else if (phase_next != pop3rp_pkg::PH_STATUS && len_next == LEN_W'(1)
                     && rx_byte == pop3rp_pkg::CH_DOT)
            begin
                hc_next = 1'b1;
            end
            else if (phase_next != pop3rp_pkg::PH_STATUS && hc_next
                     && phase_next != pop3rp_pkg::PH_BODY)
            begin
                fail = 1'b1;
            end
            else
            begin
                // a stuffed leading dot on a body line is dropped here
                hc_next = 1'b0;
                case (phase_next)
                    pop3rp_pkg::PH_STATUS:
                    begin
                        if (ok_next && kind_next == pop3rp_pkg::KIND_STAT)
                        begin
                            if (sp_next == 2'd0)
                            begin
                                if (rx_byte == pop3rp_pkg::CH_SPACE)
                                    sp_next = 2'd1;
                            end
                            else if (sp_next == 2'd1)
                            begin
                                if (rx_byte == pop3rp_pkg::CH_SPACE)
                                    sp_next = 2'd2;
                                else if (pop3rp_pkg::is_digit(rx_byte))
                                    acc_next = pop3rp_pkg::acc_step(acc_next, rx_byte);
                                else
                                    fail = 1'b1;
                            end
                        end
                    end
                    pop3rp_pkg::PH_LIST:
                    begin
                        if (sp_next == 2'd0)
                        begin
                            if (rx_byte == pop3rp_pkg::CH_SPACE)
                                sp_next = 2'd1;
                        end
                        else if (pop3rp_pkg::is_digit(rx_byte))
                        begin
                            acc_next = pop3rp_pkg::acc_step(acc_next, rx_byte);
                        end
                        else
                        begin
                            fail = 1'b1;
                        end
                    end
                    pop3rp_pkg::PH_UIDL:
                    begin
                        if (sp_next == 2'd0)
                        begin
                            if (rx_byte == pop3rp_pkg::CH_SPACE)
                                sp_next = 2'd1;
                        end
                        else
                        begin
                            // id bytes go out one behind so the last one can be flagged
                            if (hiv_next)
                            begin
                                r0.kind = pop3rp_pkg::RK_TEXT;
                                r0.text = hib_next;
                                cnt     = 2'd1;
                            end
                            hib_next = rx_byte;
                            hiv_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        r0.kind = pop3rp_pkg::RK_TEXT;
                        r0.text = rx_byte;
                        cnt     = 2'd1;
                    end
                endcase
            end
        end

        if (fail)
        begin
            r0         = '0;
            r1         = '0;
            r0.kind    = pop3rp_pkg::RK_ERROR;
            r0.done    = 1'b1;
            cnt        = 2'd1;
            clr        = 1'b1;
            phase_next = pop3rp_pkg::PH_IDLE;
        end

        if (clr)
        begin
            cr_next  = 1'b0;
            len_next = '0;
            sp_next  = 2'd0;
            acc_next = '0;
            hc_next  = 1'b0;
            hib_next = '0;
            hiv_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= pop3rp_pkg::PH_IDLE;
            kind_reg  <= '0;
            ok_reg    <= 1'b0;
            cr_reg    <= 1'b0;
            len_reg   <= '0;
            sp_reg    <= 2'd0;
            acc_reg   <= '0;
            hc_reg    <= 1'b0;
            hib_reg   <= '0;
            hiv_reg   <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            kind_reg  <= kind_next;
            ok_reg    <= ok_next;
            cr_reg    <= cr_next;
            len_reg   <= len_next;
            sp_reg    <= sp_next;
            acc_reg   <= acc_next;
            hc_reg    <= hc_next;
            hib_reg   <= hib_next;
            hiv_reg   <= hiv_next;
        end
    end

    always_comb
    begin
        push.cnt = accept ? cnt : 2'd0;
        push.r0  = r0;
        push.r1  = r1;
    end

endmodule

// ===== hw/rtl/pop3rp_resq.sv =====
// four-entry result queue, takes up to two results per cycle
`timescale 1ns / 1ps

module pop3rp_resq (
    input  logic                clk,
    input  logic                rst_n,
    input  pop3rp_pkg::push_t   push,
    output logic                room,
    output logic                out_valid,
    input  logic                out_ready,
    output pop3rp_pkg::result_t head
);

    pop3rp_pkg::result_t entry_reg [4];
    logic [1:0] wptr_reg, wptr_next;
    logic [1:0] rptr_reg, rptr_next;
    logic [2:0] count_reg, count_next;
    logic       pop;

    assign room      = (count_reg <= 3'd2);
    assign out_valid = (count_reg != 3'd0);
    assign head      = entry_reg[rptr_reg];
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wptr_next  = wptr_reg + push.cnt;
        rptr_next  = rptr_reg + {1'b0, pop};
        count_next = count_reg + {1'b0, push.cnt} - {2'd0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
            entry_reg[wptr_reg] <= push.r0;
        if (push.cnt == 2'd2)
            entry_reg[wptr_reg + 2'd1] <= push.r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 2'd0;
            rptr_reg  <= 2'd0;
            count_reg <= 3'd0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

endmodule

// ===== dv/pop3rp_tb_pkg.sv =====
// reply tracker class: predicts parser results per received byte and checks them in order
`timescale 1ns / 1ps

package pop3rp_tb_pkg;

    import pop3rp_pkg::*;

    class pop3_reply_tracker;
        phase_t      phase;
        logic [2:0]  kind;
        bit          ok;
        bit          prev_cr;
        int unsigned line_len;
        bit [1:0]    spaces;
        logic [31:0] acc;
        bit          held_dot;
        logic [7:0]  held_id;
        bit          held_id_vld;
        result_t     pending_results[$];
        int unsigned mismatch_count;

        function new();
            kind = KIND_SINGLE;
            ok = 1'b0;
            mismatch_count = 0;
            go_idle();
        endfunction

        function void clear_line();
            prev_cr = 1'b0;
            line_len = 0;
            spaces = 2'd0;
            acc = 32'd0;
            held_dot = 1'b0;
            held_id = 8'd0;
            held_id_vld = 1'b0;
        endfunction

        function void go_idle();
            clear_line();
            phase = PH_IDLE;
        endfunction

        function void push_result(logic [2:0] rk, logic okv, logic [31:0] num,
                                  logic [7:0] txt, logic iend, logic done);
            result_t r;
            r.kind = rk;
            r.ok = okv;
            r.number = num;
            r.text = txt;
            r.item_end = iend;
            r.done = done;
            pending_results.insert(pending_results.size(), r);
        endfunction

        function void raise_error();
            go_idle();
            push_result(RK_ERROR, 1'b0, 32'd0, 8'd0, 1'b0, 1'b1);
        endfunction

        // decimal accumulate with saturation, returns 0 on a non-digit
        function bit take_digit(logic [7:0] b);
            logic [63:0] wide;
            if (b < CH_ZERO || b > CH_NINE)
                return 1'b0;
            wide = 64'(acc) * 64'd10 + 64'(b - CH_ZERO);
            acc = (wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
            return 1'b1;
        endfunction

        function void close_line();
            if (phase == PH_STATUS)
            begin
                if (!ok || kind == KIND_SINGLE)
                begin
                    push_result(RK_STATUS, ok, 32'd0, 8'd0, 1'b0, 1'b1);
                    go_idle();
                    return;
                end
                if (kind == KIND_STAT)
                begin
                    if (spaces == 2'd0)
                    begin
                        raise_error();
                        return;
                    end
                    push_result(RK_STATUS, 1'b1, 32'd0, 8'd0, 1'b0, 1'b0);
                    push_result(RK_NUMBER, 1'b0, acc, 8'd0, 1'b0, 1'b1);
                    go_idle();
                    return;
                end
                push_result(RK_STATUS, 1'b1, 32'd0, 8'd0, 1'b0, 1'b0);
                clear_line();
                phase = (kind == KIND_LIST) ? PH_LIST : (kind == KIND_UIDL) ? PH_UIDL : PH_BODY;
                return;
            end
            // a line that is exactly a dot ends the list or body
            if (held_dot)
            begin
                push_result(RK_END, 1'b0, 32'd0, 8'd0, 1'b0, 1'b1);
                go_idle();
                return;
            end
            case (phase)
                PH_LIST:
                begin
                    if (spaces == 2'd0)
                    begin
                        raise_error();
                        return;
                    end
                    push_result(RK_NUMBER, 1'b0, acc, 8'd0, 1'b0, 1'b0);
                end
                PH_UIDL:
                begin
                    if (spaces == 2'd0)
                    begin
                        raise_error();
                        return;
                    end
                    if (held_id_vld)
                        push_result(RK_TEXT, 1'b0, 32'd0, held_id, 1'b1, 1'b0);
                end
                default:
                begin
                    push_result(RK_TEXT, 1'b0, 32'd0, CH_CR, 1'b0, 1'b0);
                    push_result(RK_TEXT, 1'b0, 32'd0, CH_LF, 1'b0, 1'b0);
                end
            endcase
            clear_line();
        endfunction

        // called once per accepted byte transfer
        function void accept_byte(logic [7:0] b, logic [2:0] k);
            int unsigned limit;
            if (phase == PH_IDLE)
            begin
                kind = (k > KIND_BODY) ? KIND_SINGLE : k;
                ok = (b == CH_PLUS);
                clear_line();
                phase = PH_STATUS;
            end
            limit = (phase == PH_STATUS) ? DEF_MAX_STATUS_LEN : DEF_MAX_LINE_LEN;
            if (line_len >= limit)
            begin
                raise_error();
                return;
            end
            line_len++;
            if (prev_cr)
            begin
                if (b != CH_LF)
                    raise_error();
                else
                    close_line();
                return;
            end
            if (b == CH_CR)
            begin
                prev_cr = 1'b1;
                return;
            end
            if (phase != PH_STATUS)
            begin
                if (line_len == 1 && b == CH_DOT)
                begin
                    held_dot = 1'b1;
                    return;
                end
                // a leading dot only unstuffs in a body
                if (held_dot)
                begin
                    if (phase != PH_BODY)
                    begin
                        raise_error();
                        return;
                    end
                    held_dot = 1'b0;
                end
            end
            case (phase)
                PH_STATUS:
                begin
                    if (ok && kind == KIND_STAT)
                    begin
                        if (spaces == 2'd0)
                        begin
                            if (b == CH_SPACE)
                                spaces = 2'd1;
                        end
                        else if (spaces == 2'd1)
                        begin
                            if (b == CH_SPACE)
                                spaces = 2'd2;
                            else if (!take_digit(b))
                                raise_error();
                        end
                    end
                end
                PH_LIST:
                begin
                    if (spaces == 2'd0)
                    begin
                        if (b == CH_SPACE)
                            spaces = 2'd1;
                    end
                    else if (!take_digit(b))
                        raise_error();
                end
                PH_UIDL:
                begin
                    if (spaces == 2'd0)
                    begin
                        if (b == CH_SPACE)
                            spaces = 2'd1;
                    end
                    else
                    begin
                        // one byte held back so the last one can carry item_end
                        if (held_id_vld)
                            push_result(RK_TEXT, 1'b0, 32'd0, held_id, 1'b0, 1'b0);
                        held_id = b;
                        held_id_vld = 1'b1;
                    end
                end
                default:
                    push_result(RK_TEXT, 1'b0, 32'd0, b, 1'b0, 1'b0);
            endcase
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s expected %0d actual %0d", field, want, got);
                mismatch_count++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending_results.size() == 0)
            begin
                $error("result_kind expected none actual %0d", got.kind);
                mismatch_count++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("result_kind", 32'(want.kind), 32'(got.kind));
            compare_field("status_ok", 32'(want.ok), 32'(got.ok));
            compare_field("number_value", want.number, got.number);
            compare_field("text_byte", 32'(want.text), 32'(got.text));
            compare_field("item_end", 32'(want.item_end), 32'(got.item_end));
            compare_field("response_done", 32'(want.done), 32'(got.done));
        endfunction
    endclass

endpackage

// ===== dv/tb_top.sv =====
// testbench top: feeds pop3 response byte streams to the parser and checks every result
`timescale 1ns / 1ps

module tb_top;

    import pop3rp_pkg::*;
    import pop3rp_tb_pkg::*;

    localparam int          CYCLE_LIMIT  = 300000;
    localparam int          RANDOM_BYTES = 265;
    localparam int          DRAIN_CYCLES = 20;
    localparam int          HOLD_AT      = 40;
    localparam int          HOLD_CYCLES  = 250;
    localparam int          CALM_LO      = 50;
    localparam int          CALM_HI      = 120;
    localparam logic [7:0]  CH_MINUS     = 8'h2D;
    localparam logic [2:0]  KIND_TOP_CODE = 3'd7;

    typedef struct packed {
        logic [7:0] data;
        logic [2:0] kind;
    } rx_item_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  rx_byte;
    logic [2:0]  response_kind;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  result_kind;
    logic        status_ok;
    logic [31:0] number_value;
    logic [7:0]  text_byte;
    logic        item_end;
    logic        response_done;

    rx_item_t          stream_q[$];
    pop3_reply_tracker tracker;
    int unsigned       cycle_count = 0;
    int unsigned       results_seen = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    pop3_response_parser_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .rx_byte       (rx_byte),
        .response_kind (response_kind),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .result_kind   (result_kind),
        .status_ok     (status_ok),
        .number_value  (number_value),
        .text_byte     (text_byte),
        .item_end      (item_end),
        .response_done (response_done)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ---------------- byte stream builders ----------------

    // kind only matters on the first byte of a response, so it is random elsewhere
    function automatic void put_byte(logic [7:0] b);
        rx_item_t it;
        it.data = b;
        it.kind = 3'($urandom_range(7));
        stream_q.insert(stream_q.size(), it);
    endfunction

    function automatic void put_first(logic [7:0] b, logic [2:0] k);
        rx_item_t it;
        it.data = b;
        it.kind = k;
        stream_q.insert(stream_q.size(), it);
    endfunction

    function automatic void put_str(string s);
        for (int i = 0; i < s.len(); i++)
            put_byte(s[i]);
    endfunction

    function automatic void put_crlf();
        put_byte(CH_CR);
        put_byte(CH_LF);
    endfunction

    function automatic void put_dot_line();
        put_byte(CH_DOT);
        put_crlf();
    endfunction

    function automatic void put_digits(int n);
        repeat (n)
            put_byte(8'(CH_ZERO + $urandom_range(9)));
    endfunction

    function automatic logic [7:0] any_but_cr();
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while (b == CH_CR);
        return b;
    endfunction

    function automatic void put_text(int n);
        repeat (n)
            put_byte(any_but_cr());
    endfunction

    function automatic void put_ok_status(logic [2:0] k);
        put_first(CH_PLUS, k);
        put_str("OK");
        put_crlf();
    endfunction

    function automatic void put_err_status(logic [2:0] k);
        put_first(CH_MINUS, k);
        put_str("ERR");
        put_text($urandom_range(3));
        put_crlf();
    endfunction

    // CR followed by something other than LF
    function automatic void put_bare_cr();
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while (b == CH_LF);
        put_byte(CH_CR);
        put_byte(b);
    endfunction

    function automatic void build_directed();
        // kind codes above body fall back to a single status line
        put_first(CH_PLUS, KIND_TOP_CODE);
        put_crlf();
        put_first(CH_PLUS, KIND_STAT);
        put_byte(CH_SPACE);
        put_byte(CH_NINE);
        put_crlf();
        // list with an empty size
        put_first(CH_PLUS, KIND_LIST);
        put_crlf();
        put_str("1 ");
        put_crlf();
        put_dot_line();
        put_first(CH_PLUS, KIND_UIDL);
        put_crlf();
        put_str("1 a");
        put_crlf();
        put_dot_line();
        // dot-stuffed body line
        put_first(CH_PLUS, KIND_BODY);
        put_crlf();
        put_byte(CH_DOT);
        put_byte(CH_DOT);
        put_crlf();
        put_dot_line();
        put_first(CH_MINUS, KIND_SINGLE);
        put_byte(CH_CR);
        put_byte(CH_MINUS);
    endfunction

    function automatic void gen_single();
        if ($urandom_range(1))
        begin
            put_first(CH_PLUS, $urandom_range(1) ? KIND_SINGLE : 3'($urandom_range(5, 7)));
            put_text($urandom_range(6));
            put_crlf();
        end
        else
            put_err_status(3'($urandom_range(7)));
    endfunction

    function automatic void gen_stat();
        int sel;
        sel = $urandom_range(7);
        case (sel)
            0: put_err_status(KIND_STAT);
            1: put_ok_status(KIND_STAT);
            2:
            begin
                put_first(CH_PLUS, KIND_STAT);
                put_str("OK ");
                put_crlf();
            end
            3:
            begin
                put_first(CH_PLUS, KIND_STAT);
                put_str("OK ");
                put_digits($urandom_range(2));
                put_byte(8'($urandom_range(58, 255)));
            end
            4:
            begin
                // large enough to saturate
                put_first(CH_PLUS, KIND_STAT);
                put_str("OK ");
                put_byte(CH_NINE);
                put_digits($urandom_range(10, 13));
                put_crlf();
            end
            default:
            begin
                put_first(CH_PLUS, KIND_STAT);
                put_str("OK ");
                put_digits($urandom_range(1, 6));
                if ($urandom_range(1))
                begin
                    put_byte(CH_SPACE);
                    put_text($urandom_range(5));
                end
                put_crlf();
            end
        endcase
    endfunction

    function automatic void gen_list();
        int sel;
        if ($urandom_range(9) == 0)
        begin
            put_err_status(KIND_LIST);
            return;
        end
        put_ok_status(KIND_LIST);
        repeat ($urandom_range(4))
        begin
            sel = $urandom_range(19);
            if (sel == 0)
            begin
                put_digits($urandom_range(1, 2));
                put_crlf();
                return;
            end
            if (sel == 1)
            begin
                put_digits(1);
                put_byte(CH_SPACE);
                put_digits($urandom_range(2));
                put_byte(8'($urandom_range(58, 255)));
                return;
            end
            if (sel == 2)
            begin
                put_byte(CH_DOT);
                put_str("1 5");
                return;
            end
            put_digits($urandom_range(1, 3));
            put_byte(CH_SPACE);
            put_digits($urandom_range(12));
            put_crlf();
        end
        put_dot_line();
    endfunction

    function automatic void gen_uidl();
        int sel;
        if ($urandom_range(9) == 0)
        begin
            put_err_status(KIND_UIDL);
            return;
        end
        put_ok_status(KIND_UIDL);
        repeat ($urandom_range(4))
        begin
            sel = $urandom_range(19);
            if (sel == 0)
            begin
                put_digits($urandom_range(1, 2));
                put_crlf();
                return;
            end
            if (sel == 1)
            begin
                put_byte(CH_DOT);
                put_str("2 x");
                return;
            end
            if (sel == 2)
            begin
                // bare CR with an id byte still held
                put_str("3 ab");
                put_bare_cr();
                return;
            end
            put_digits($urandom_range(1, 3));
            put_byte(CH_SPACE);
            put_text($urandom_range(8));
            put_crlf();
        end
        put_dot_line();
    endfunction

    function automatic void gen_body();
        int sel;
        if ($urandom_range(9) == 0)
        begin
            put_err_status(KIND_BODY);
            return;
        end
        put_ok_status(KIND_BODY);
        repeat ($urandom_range(4))
        begin
            sel = $urandom_range(9);
            if (sel == 0)
            begin
                put_text($urandom_range(4));
                put_bare_cr();
                return;
            end
            if (sel <= 2)
            begin
                put_byte(CH_DOT);
                put_byte(any_but_cr());
            end
            put_text($urandom_range(10));
            put_crlf();
        end
        put_dot_line();
    endfunction

    function automatic void build_random();
        int base;
        base = stream_q.size();
        while (stream_q.size() < base + RANDOM_BYTES)
        begin
            case ($urandom_range(99)) inside
                [0:11]:  gen_single();
                [12:23]: gen_stat();
                [24:43]: gen_list();
                [44:63]: gen_uidl();
                [64:87]: gen_body();
                default: repeat ($urandom_range(1, 8)) put_byte(8'($urandom_range(255)));
            endcase
        end
    endfunction

    // ---------------- drivers ----------------

    task automatic drive_stream(input int unsigned calm_lo, input int unsigned calm_hi);
        rx_item_t    it;
        int unsigned idx;
        idx = 0;
        while (stream_q.size() != 0)
        begin
            it = stream_q.pop_front();
            while (!(idx >= calm_lo && idx < calm_hi) && $urandom_range(99) < 37)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid <= 1'b1;
            rx_byte <= it.data;
            response_kind <= it.kind;
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            tracker.accept_byte(it.data, it.kind);
            idx++;
        end
    endtask

    task automatic wait_drained();
        while (tracker.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    // result side: random stalls, one long hold-off, one stall-free stretch
    initial
    begin
        result_t     got;
        int unsigned hold;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                got.kind = result_kind;
                got.ok = status_ok;
                got.number = number_value;
                got.text = text_byte;
                got.item_end = item_end;
                got.done = response_done;
                tracker.check_result(got);
                results_seen++;
                if (results_seen == HOLD_AT)
                begin
                    out_ready <= 1'b0;
                    for (hold = 0; hold < HOLD_CYCLES; hold++)
                        @(posedge clk);
                    continue;
                end
            end
            out_ready <= (results_seen >= CALM_LO && results_seen < CALM_HI) ||
                         ($urandom_range(99) >= 37);
        end
    end

    initial
    begin
        tracker = new();
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        rx_byte <= 8'd0;
        response_kind <= KIND_SINGLE;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        build_directed();
        drive_stream(0, 0);
        in_valid <= 1'b0;
        // sender pauses until every result of the directed part is out
        wait_drained();

        build_random();
        drive_stream(60, 180);
        in_valid <= 1'b0;
        wait_drained();

        if (tracker.mismatch_count == 0 && tracker.pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/pop3rp_pkg.sv
hw/rtl/pop3rp_core.sv
hw/rtl/pop3rp_resq.sv
hw/rtl/pop3_response_parser_top.sv
dv/pop3rp_tb_pkg.sv
dv/tb_top.sv
